/* hdl/assert_macros.svh */
// assertion macros included by the waiter core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock after reset
`define MPSW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked on every clock after reset
`define MPSW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/mpsw_pkg.sv */
// shared constants, codes and control structs of the pattern waiter
`timescale 1ns / 1ps

package mpsw_pkg;

  localparam int MAX_PATTERNS    = 4;
  localparam int MAX_PATTERN_LEN = 16;

  localparam int POS_W  = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
  localparam int SLOT_W = 2;
  localparam int CPOS_W = 4;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 3;
  localparam int TMO_W  = 32;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_LOAD  = 2'd2,
    OP_START = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_SEARCHING = 2'd0,
    ST_MATCHED   = 2'd1,
    ST_TIMEOUT   = 2'd2,
    ST_IDLE      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_PATTERN_COUNT = 2'd0,
    REG_TIMEOUT_TICKS = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic              clr;
    logic              step;
    logic              load;
    logic              last;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] data;
  } lane_cmd_t;

  typedef struct packed {
    logic hit;
    logic done;
  } lane_stat_t;

  typedef struct packed {
    logic clr;
    logic tick;
  } tmr_cmd_t;

  typedef struct packed {
    logic expired;
    logic expired_tick;
  } tmr_stat_t;

endpackage

/* hdl/mpsw_lane.sv */
// one pattern lane: pattern store, length, progress counter and byte compare
`timescale 1ns / 1ps

module mpsw_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mpsw_pkg::lane_cmd_t  cmd,
  output mpsw_pkg::lane_stat_t stat
);

  logic [mpsw_pkg::BYTE_W-1:0] pat_r [mpsw_pkg::MAX_PATTERN_LEN];
  logic [mpsw_pkg::LEN_W-1:0]  len_r;
  logic [mpsw_pkg::POS_W-1:0]  prog_r;
  logic [mpsw_pkg::POS_W-1:0]  prog_nxt;
  logic [mpsw_pkg::LEN_W-1:0]  prog_ext;
  logic [mpsw_pkg::LEN_W-1:0]  prog_inc;
  logic                        hit;

  assign prog_ext = mpsw_pkg::LEN_W'(prog_r);
  assign prog_inc = prog_ext + mpsw_pkg::LEN_W'(1);
  assign hit      = (prog_ext < len_r) && (pat_r[prog_r] == cmd.data);

  assign stat.hit  = hit;
  assign stat.done = hit && (prog_inc == len_r);

  always_comb begin
    prog_nxt = prog_r;
    if (cmd.clr) begin
      prog_nxt = '0;
    end else if (cmd.step) begin
      // a mismatch drops back to the start without a second compare
      prog_nxt = hit ? prog_inc[mpsw_pkg::POS_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_r <= '0;
    end else begin
      prog_r <= prog_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pat_r[cmd.pos] <= cmd.data;
      if (cmd.last) begin
        len_r <= mpsw_pkg::LEN_W'(cmd.pos) + mpsw_pkg::LEN_W'(1);
      end
    end
  end

endmodule

/* hdl/mpsw_timer.sv */
// elapsed tick counter with saturation and timeout compare
`timescale 1ns / 1ps

module mpsw_timer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mpsw_pkg::tmr_cmd_t         cmd,
  input  logic [mpsw_pkg::TMO_W-1:0] timeout,
  output mpsw_pkg::tmr_stat_t        stat
);

  logic [mpsw_pkg::TMO_W-1:0] elapsed_r;
  logic [mpsw_pkg::TMO_W-1:0] elapsed_nxt;
  logic [mpsw_pkg::TMO_W-1:0] elapsed_inc;

  assign elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + mpsw_pkg::TMO_W'(1);

  assign stat.expired      = (|timeout) && (elapsed_r >= timeout);
  assign stat.expired_tick = (|timeout) && (elapsed_inc >= timeout);

  always_comb begin
    elapsed_nxt = elapsed_r;
    if (cmd.clr) begin
      elapsed_nxt = '0;
    end else if (cmd.tick) begin
      elapsed_nxt = elapsed_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else begin
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

/* hdl/multi_pattern_stream_waiter_core.sv */
// top level of the multi-pattern stream waiter
//
// in_*  : one transaction per item; in_tuser is the operation (byte, tick,
//         load, start), in_tdata the byte, slot and position, in_tlast
//         marks the final byte of a pattern being loaded.
// out_* : one transaction per item; out_tuser is the status (searching,
//         matched, timed out, not armed), out_tdata the matched slot.
// cfg_* : register writes (pattern count, timeout in ticks), always ready;
//         write only while no item is in flight.
// an item is captured in the input register and is worked out while it
// moves into the output register, which holds its result until taken.
// one item per cycle is sustained while out_tready stays high; the limit
// is the single compare pass over all pattern lanes between the registers.
// if the receiver stalls, the output register holds and the input register
// still takes one more item; then in_tready drops until out_tready returns.
// reset clears the armed flag, progress counters, elapsed ticks and both
// registers (pattern count 1, timeout 0); pattern storage is not cleared
// and must be loaded before a search.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_pattern_stream_waiter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // data_byte[7:0], pattern_slot[9:8], char_position[13:10]
  input  logic [1:0]  in_tuser,  // operation[1:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // matched_slot[1:0]
  output logic [1:0]  out_tuser, // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NP = mpsw_pkg::MAX_PATTERNS;

  // configuration
  logic [mpsw_pkg::CNT_W-1:0] pat_count_r;
  logic [mpsw_pkg::TMO_W-1:0] timeout_r;

  // input register
  logic                          s1_valid_r;
  mpsw_pkg::op_t                 s1_op_r;
  logic [mpsw_pkg::BYTE_W-1:0]   s1_byte_r;
  logic [mpsw_pkg::SLOT_W-1:0]   s1_slot_r;
  logic [mpsw_pkg::CPOS_W-1:0]   s1_pos_r;
  logic                          s1_last_r;

  // output register
  logic                          out_valid_r;
  mpsw_pkg::status_t             out_status_r;
  mpsw_pkg::status_t             out_status_nxt;
  logic [mpsw_pkg::SLOT_W-1:0]   out_slot_r;
  logic [mpsw_pkg::SLOT_W-1:0]   out_slot_nxt;

  logic                          armed_r;
  logic                          armed_nxt;
  logic                          advance;

  mpsw_pkg::lane_cmd_t           lane_cmd  [NP];
  mpsw_pkg::lane_stat_t          lane_stat [NP];
  mpsw_pkg::tmr_cmd_t            tmr_cmd;
  mpsw_pkg::tmr_stat_t           tmr_stat;

  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = 8'(out_slot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_count_r <= mpsw_pkg::CNT_W'(1);
      timeout_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mpsw_pkg::REG_PATTERN_COUNT: pat_count_r <= cfg_data[mpsw_pkg::CNT_W-1:0];
        mpsw_pkg::REG_TIMEOUT_TICKS: timeout_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= mpsw_pkg::op_t'(in_tuser);
      s1_byte_r <= in_tdata[7:0];
      s1_slot_r <= in_tdata[9:8];
      s1_pos_r  <= in_tdata[13:10];
      s1_last_r <= in_tlast;
    end
  end

  // lane commands and the ordered match search
  always_comb begin
    logic stop;
    stop           = 1'b0;
    armed_nxt      = armed_r;
    out_status_nxt = armed_r ? mpsw_pkg::ST_SEARCHING : mpsw_pkg::ST_IDLE;
    out_slot_nxt   = '0;
    tmr_cmd.clr    = 1'b0;
    tmr_cmd.tick   = 1'b0;
    for (int i = 0; i < NP; i++) begin
      lane_cmd[i].clr  = 1'b0;
      lane_cmd[i].step = 1'b0;
      lane_cmd[i].load = 1'b0;
      lane_cmd[i].last = s1_last_r;
      lane_cmd[i].pos  = mpsw_pkg::POS_W'(s1_pos_r);
      lane_cmd[i].data = s1_byte_r;
    end
    if (advance) begin
      case (s1_op_r)
        mpsw_pkg::OP_START: begin
          for (int i = 0; i < NP; i++) begin
            lane_cmd[i].clr = 1'b1;
          end
          tmr_cmd.clr    = 1'b1;
          armed_nxt      = 1'b1;
          out_status_nxt = mpsw_pkg::ST_SEARCHING;
        end
        mpsw_pkg::OP_LOAD: begin
          for (int i = 0; i < NP; i++) begin
            lane_cmd[i].load = (int'(s1_slot_r) == i) &&
                               (int'(s1_pos_r) < mpsw_pkg::MAX_PATTERN_LEN);
          end
        end
        mpsw_pkg::OP_TICK: begin
          if (armed_r) begin
            tmr_cmd.tick = 1'b1;
            if (tmr_stat.expired_tick) begin
              armed_nxt      = 1'b0;
              out_status_nxt = mpsw_pkg::ST_TIMEOUT;
            end
          end
        end
        mpsw_pkg::OP_BYTE: begin
          if (armed_r) begin
            if (tmr_stat.expired) begin
              armed_nxt      = 1'b0;
              out_status_nxt = mpsw_pkg::ST_TIMEOUT;
            end else begin
              // lanes past the first completed one keep their counters
              for (int i = 0; i < NP; i++) begin
                if (i < int'(pat_count_r) && !stop) begin
                  lane_cmd[i].step = 1'b1;
                  if (lane_stat[i].done) begin
                    stop           = 1'b1;
                    armed_nxt      = 1'b0;
                    out_status_nxt = mpsw_pkg::ST_MATCHED;
                    out_slot_nxt   = mpsw_pkg::SLOT_W'(i);
                  end
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < NP; g++) begin : g_lane
    mpsw_lane u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .cmd  (lane_cmd[g]),
      .stat (lane_stat[g])
    );
  end

  mpsw_timer u_timer (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (tmr_cmd),
    .timeout(timeout_r),
    .stat   (tmr_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      armed_r <= armed_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
    end
  end

  `MPSW_ASSERT_NXT(a_start_arms, advance && s1_op_r == mpsw_pkg::OP_START, armed_r)
  `MPSW_ASSERT_IMP(a_slot_only_on_match,
                   out_valid_r && out_status_r != mpsw_pkg::ST_MATCHED, out_slot_r == '0)
  `MPSW_ASSERT_IMP(a_stall_only_when_full, !in_tready,
                   s1_valid_r && out_valid_r && !out_tready)
  `MPSW_ASSERT_NXT(a_result_ends_wait,
                   advance && (out_status_nxt == mpsw_pkg::ST_MATCHED ||
                               out_status_nxt == mpsw_pkg::ST_TIMEOUT), !armed_r)

endmodule
